>>> hw/rtl/cbm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the cartridge bank mapper.
// No dependencies; used by cartridge_bank_mapper_with_irq_counter_core.
package cbm_pkg;

    // Field widths of the stream items and configuration registers.
    localparam int CMD_W        = 2;
    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int KIND_W       = 3;
    localparam int OFFSET_W     = 21;
    localparam int SLOT_W       = 2;
    localparam int MIRROR_W     = 2;
    localparam int PRG_COUNT_W  = 9;
    localparam int CHR_COUNT_W  = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 2;
    localparam int CHR_SLOTS    = 8;
    localparam int CHR_BANK_W   = 11;
    localparam int PRG_BANK_W   = 8;
    localparam int PRG_SLOTS    = 3;
    localparam int OFFSET_BITS  = 21;

    // Remainder unit: dividend up to 11 bits, divisor up to 2048.
    localparam int DIV_NUM_W    = 11;
    localparam int DIV_DEN_W    = 12;
    localparam int DIV_CNT_W    = 4;

    // Reset values of the configuration registers.
    localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 9'd32;
    localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RESET = 12'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHR  = 3'd0,
        KIND_NT   = 3'd1,
        KIND_RAM  = 3'd2,
        KIND_PRG  = 3'd3,
        KIND_NONE = 3'd4
    } kind_t;

    // 8K regions of the bus address (address bits 15..13).
    typedef enum logic [2:0] {
        RGN_CHR    = 3'd0,
        RGN_NT     = 3'd1,
        RGN_IO     = 3'd2,
        RGN_WINDOW = 3'd3,
        RGN_SELECT = 3'd4,
        RGN_LOAD   = 3'd5,
        RGN_AUDIO  = 3'd6,
        RGN_FIXED  = 3'd7
    } region_t;

    // Command register codes selected by a write to 0x8000.
    localparam logic [3:0] CS_CHR_FIRST = 4'd0;
    localparam logic [3:0] CS_CHR_LAST  = 4'd7;
    localparam logic [3:0] CS_WINDOW    = 4'd8;
    localparam logic [3:0] CS_PRG_FIRST = 4'd9;
    localparam logic [3:0] CS_PRG_LAST  = 4'd11;
    localparam logic [3:0] CS_MIRROR    = 4'd12;
    localparam logic [3:0] CS_IRQ_CTRL  = 4'd13;
    localparam logic [3:0] CS_CNT_LO    = 4'd14;
    localparam logic [3:0] CS_CNT_HI    = 4'd15;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM       = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    // Program bank count clamped to 2..256.
    function automatic logic [PRG_COUNT_W-1:0] prg_eff(input logic [PRG_COUNT_W-1:0] c);
        logic [PRG_COUNT_W-1:0] r;
        r = c;
        if (c < 9'd2) begin
            r = 9'd2;
        end else if (c > 9'd256) begin
            r = 9'd256;
        end
        return r;
    endfunction

    // Pattern bank count clamped to 1..2048.
    function automatic logic [CHR_COUNT_W-1:0] chr_eff(input logic [CHR_COUNT_W-1:0] c);
        logic [CHR_COUNT_W-1:0] r;
        r = c;
        if (c == 12'd0) begin
            r = 12'd1;
        end else if (c > 12'd2048) begin
            r = 12'd2048;
        end
        return r;
    endfunction

    // Preset value of the switchable program banks: effective count minus two.
    function automatic logic [PRG_BANK_W-1:0] prg_preset(input logic [PRG_COUNT_W-1:0] c);
        logic [PRG_COUNT_W-1:0] e;
        e = prg_eff(c) - 9'd2;
        return e[PRG_BANK_W-1:0];
    endfunction

endpackage

>>> hw/rtl/cartridge_bank_mapper_with_irq_counter_core.sv
`timescale 1ns / 1ps
// Top level of the cartridge bank mapper with its 16-bit IRQ down counter.
// Depends on cbm_pkg for codes, widths and count clamping functions.
//
// Each input item is one bus access or one counter tick and yields exactly one result
// item with the target region, byte offset, nametable slot, mirroring code and IRQ level.
// Pattern and switchable program bank numbers are reduced modulo the effective bank count
// by one shared restoring remainder unit that retires one dividend bit per cycle. Items
// that need a reduction (pattern and ROM window accesses, switchable program reads, bank
// loads) pass from ST_IDLE through ST_DIV to ST_OUT; all other items go from ST_IDLE
// straight to ST_OUT. The input is held until ST_OUT commits the result into the output
// register, and a stalled output keeps the item waiting in ST_OUT. One item is in
// flight at a time; the next item is taken while the previous result still waits in
// the output register. Configuration is written through cfg_we / cfg_index /
// cfg_wdata; writing the program bank count also presets the three switchable banks.
module cartridge_bank_mapper_with_irq_counter_core #(
    parameter int OFFSET_BITS = cbm_pkg::OFFSET_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // target_offset[20:0], nametable_slot[22:21],
                                   // mirroring_mode[24:23], irq_line[25], zero[31:26]
    output logic [2:0]  m_tuser    // target_kind[2:0]
);

    localparam int OW        = cbm_pkg::OFFSET_W;
    localparam int MASK_BITS = (OFFSET_BITS < OW) ? OFFSET_BITS : OW;
    localparam logic [OW-1:0] OFF_MASK = OW'((64'd1 << MASK_BITS) - 64'd1);
    localparam logic [cbm_pkg::DIV_CNT_W-1:0] DIV_LAST =
        cbm_pkg::DIV_CNT_W'(cbm_pkg::DIV_NUM_W - 1);

    // Sequencer and latched item.
    cbm_pkg::state_t state_reg, state_next;
    logic [1:0]  cmd_reg,  cmd_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;

    // Shared remainder unit.
    logic [cbm_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [cbm_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [cbm_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [cbm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [cbm_pkg::DIV_DEN_W-1:0] trial;

    // Configuration registers.
    logic [cbm_pkg::PRG_COUNT_W-1:0] prg_count_reg, prg_count_next;
    logic [cbm_pkg::CHR_COUNT_W-1:0] chr_count_reg, chr_count_next;
    logic                            ram_present_reg, ram_present_next;

    // Mapper state.
    logic [3:0]                     cmd_sel_reg, cmd_sel_next;
    logic [cbm_pkg::CHR_BANK_W-1:0] chr_bank_reg [cbm_pkg::CHR_SLOTS];
    logic [cbm_pkg::CHR_BANK_W-1:0] chr_bank_next [cbm_pkg::CHR_SLOTS];
    logic                           win_is_ram_reg, win_is_ram_next;
    logic [cbm_pkg::PRG_BANK_W-1:0] win_bank_reg, win_bank_next;
    logic [cbm_pkg::PRG_BANK_W-1:0] prg_bank_reg [cbm_pkg::PRG_SLOTS];
    logic [cbm_pkg::PRG_BANK_W-1:0] prg_bank_next [cbm_pkg::PRG_SLOTS];
    logic [7:0]                     irq_ctrl_reg, irq_ctrl_next;
    logic [15:0]                    irq_cnt_reg, irq_cnt_next;
    logic                           irq_pend_reg, irq_pend_next;
    logic [1:0]                     mirror_reg, mirror_next;

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    logic [2:0]             m_kind_reg, m_kind_next;
    logic [OW-1:0]          m_off_reg, m_off_next;
    logic [1:0]             m_slot_reg, m_slot_next;
    logic [1:0]             m_mirror_reg, m_mirror_next;
    logic                   m_irq_reg, m_irq_next;

    // Decode of the incoming item.
    logic [1:0]  in_cmd;
    logic [15:0] in_addr;
    logic [7:0]  in_data;
    logic [2:0]  in_region;
    logic        in_access;
    logic        need_mod;
    logic        use_chr_den;
    logic [cbm_pkg::DIV_NUM_W-1:0] in_num;

    logic [cbm_pkg::PRG_COUNT_W-1:0] prg_eff_w;
    logic [cbm_pkg::CHR_COUNT_W-1:0] chr_eff_w;
    logic [cbm_pkg::PRG_COUNT_W-1:0] prg_last;

    // Result of the item being finished.
    logic [2:0]    res_kind;
    logic [OW-1:0] res_off;
    logic [1:0]    res_slot;
    logic [2:0]    cur_region;
    logic [15:0]   cnt_dec;
    logic          commit;

    assign in_cmd    = s_tuser;
    assign in_addr   = s_tdata[15:0];
    assign in_data   = s_tdata[23:16];
    assign in_region = in_addr[15:13];
    assign in_access = (in_cmd == cbm_pkg::CMD_READ) || (in_cmd == cbm_pkg::CMD_WRITE);

    assign prg_eff_w = cbm_pkg::prg_eff(prg_count_reg);
    assign chr_eff_w = cbm_pkg::chr_eff(chr_count_reg);
    assign prg_last  = prg_eff_w - 9'd1;

    assign s_tready = (state_reg == cbm_pkg::ST_IDLE);
    assign trial    = {rem_reg[cbm_pkg::DIV_DEN_W-2:0], num_reg[cbm_pkg::DIV_NUM_W-1]};
    assign cur_region = addr_reg[15:13];
    assign cnt_dec  = irq_cnt_reg - 16'd1;
    assign commit   = (state_reg == cbm_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    // Pick the bank number and modulus the item needs reduced, if any.
    always_comb begin
        need_mod    = 1'b0;
        use_chr_den = 1'b0;
        in_num      = '0;
        if (in_access) begin
            unique case (in_region)
                cbm_pkg::RGN_CHR: begin
                    need_mod    = 1'b1;
                    use_chr_den = 1'b1;
                    in_num      = chr_bank_reg[in_addr[12:10]];
                end
                cbm_pkg::RGN_WINDOW: begin
                    need_mod = !win_is_ram_reg;
                    in_num   = cbm_pkg::DIV_NUM_W'(win_bank_reg);
                end
                cbm_pkg::RGN_SELECT, cbm_pkg::RGN_LOAD, cbm_pkg::RGN_AUDIO: begin
                    if (in_cmd == cbm_pkg::CMD_READ) begin
                        need_mod = 1'b1;
                        in_num   = cbm_pkg::DIV_NUM_W'(
                            prg_bank_reg[2'(in_region - cbm_pkg::RGN_SELECT)]);
                    end else if (in_region == cbm_pkg::RGN_LOAD) begin
                        priority if (cmd_sel_reg <= cbm_pkg::CS_CHR_LAST) begin
                            need_mod    = 1'b1;
                            use_chr_den = 1'b1;
                            in_num      = cbm_pkg::DIV_NUM_W'(in_data);
                        end else if (cmd_sel_reg == cbm_pkg::CS_WINDOW) begin
                            need_mod = !in_data[6];
                            in_num   = cbm_pkg::DIV_NUM_W'(in_data[4:0]);
                        end else if (cmd_sel_reg <= cbm_pkg::CS_PRG_LAST) begin
                            need_mod = 1'b1;
                            in_num   = cbm_pkg::DIV_NUM_W'(in_data[4:0]);
                        end else begin
                            need_mod = 1'b0;
                        end
                    end
                end
                default: begin
                    need_mod = 1'b0;
                end
            endcase
        end
    end

    // Result of the finished item, from the latched item and the remainder.
    always_comb begin
        res_kind = cbm_pkg::KIND_NONE;
        res_off  = '0;
        res_slot = '0;
        if ((cmd_reg == cbm_pkg::CMD_READ) || (cmd_reg == cbm_pkg::CMD_WRITE)) begin
            unique case (cur_region)
                cbm_pkg::RGN_CHR: begin
                    res_kind = cbm_pkg::KIND_CHR;
                    res_off  = {rem_reg[cbm_pkg::CHR_BANK_W-1:0], addr_reg[9:0]};
                end
                cbm_pkg::RGN_NT: begin
                    res_kind = cbm_pkg::KIND_NT;
                    res_slot = addr_reg[11:10];
                    res_off  = OW'(addr_reg[9:0]);
                end
                cbm_pkg::RGN_WINDOW: begin
                    if (!win_is_ram_reg) begin
                        res_kind = cbm_pkg::KIND_PRG;
                        res_off  = {rem_reg[cbm_pkg::PRG_BANK_W-1:0], addr_reg[12:0]};
                    end else if (ram_present_reg) begin
                        res_kind = cbm_pkg::KIND_RAM;
                        res_off  = OW'(addr_reg[12:0]);
                    end
                end
                cbm_pkg::RGN_SELECT, cbm_pkg::RGN_LOAD, cbm_pkg::RGN_AUDIO: begin
                    if (cmd_reg == cbm_pkg::CMD_READ) begin
                        res_kind = cbm_pkg::KIND_PRG;
                        res_off  = {rem_reg[cbm_pkg::PRG_BANK_W-1:0], addr_reg[12:0]};
                    end
                end
                cbm_pkg::RGN_FIXED: begin
                    if (cmd_reg == cbm_pkg::CMD_READ) begin
                        res_kind = cbm_pkg::KIND_PRG;
                        res_off  = {prg_last[cbm_pkg::PRG_BANK_W-1:0], addr_reg[12:0]};
                    end
                end
                default: begin
                    res_kind = cbm_pkg::KIND_NONE;
                end
            endcase
        end
    end

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        data_next        = data_reg;
        den_next         = den_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        prg_count_next   = prg_count_reg;
        chr_count_next   = chr_count_reg;
        ram_present_next = ram_present_reg;
        cmd_sel_next     = cmd_sel_reg;
        chr_bank_next    = chr_bank_reg;
        win_is_ram_next  = win_is_ram_reg;
        win_bank_next    = win_bank_reg;
        prg_bank_next    = prg_bank_reg;
        irq_ctrl_next    = irq_ctrl_reg;
        irq_cnt_next     = irq_cnt_reg;
        irq_pend_next    = irq_pend_reg;
        mirror_next      = mirror_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_kind_next      = m_kind_reg;
        m_off_next       = m_off_reg;
        m_slot_next      = m_slot_reg;
        m_mirror_next    = m_mirror_reg;
        m_irq_next       = m_irq_reg;

        unique case (state_reg)
            cbm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = in_cmd;
                    addr_next = in_addr;
                    data_next = in_data;
                    num_next  = in_num;
                    rem_next  = '0;
                    cnt_next  = DIV_LAST;
                    den_next  = use_chr_den ? chr_eff_w
                                            : cbm_pkg::DIV_DEN_W'(prg_eff_w);
                    state_next = need_mod ? cbm_pkg::ST_DIV : cbm_pkg::ST_OUT;
                end
            end
            cbm_pkg::ST_DIV: begin
                // One restoring remainder step per cycle, dividend MSB first.
                rem_next = (trial >= den_reg) ? (trial - den_reg) : trial;
                num_next = {num_reg[cbm_pkg::DIV_NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = cbm_pkg::ST_OUT;
                end
            end
            cbm_pkg::ST_OUT: begin
                if (commit) begin
                    state_next = cbm_pkg::ST_IDLE;
                    if (cmd_reg == cbm_pkg::CMD_TICK) begin
                        if (irq_ctrl_reg[7]) begin
                            irq_cnt_next = cnt_dec;
                            if ((cnt_dec == 16'hFFFF) && irq_ctrl_reg[0]) begin
                                irq_pend_next = 1'b1;
                            end
                        end
                    end else if (cmd_reg == cbm_pkg::CMD_WRITE) begin
                        if (cur_region == cbm_pkg::RGN_SELECT) begin
                            cmd_sel_next = data_reg[3:0];
                        end else if (cur_region == cbm_pkg::RGN_LOAD) begin
                            priority if (cmd_sel_reg <= cbm_pkg::CS_CHR_LAST) begin
                                chr_bank_next[cmd_sel_reg[2:0]] =
                                    rem_reg[cbm_pkg::CHR_BANK_W-1:0];
                            end else if (cmd_sel_reg == cbm_pkg::CS_WINDOW) begin
                                win_is_ram_next = data_reg[6];
                                if (!data_reg[6]) begin
                                    win_bank_next = rem_reg[cbm_pkg::PRG_BANK_W-1:0];
                                end
                            end else if (cmd_sel_reg <= cbm_pkg::CS_PRG_LAST) begin
                                prg_bank_next[2'(cmd_sel_reg - cbm_pkg::CS_PRG_FIRST)] =
                                    rem_reg[cbm_pkg::PRG_BANK_W-1:0];
                            end else if (cmd_sel_reg == cbm_pkg::CS_MIRROR) begin
                                mirror_next = data_reg[1:0] ^ 2'b10;
                            end else if (cmd_sel_reg == cbm_pkg::CS_IRQ_CTRL) begin
                                irq_pend_next = 1'b0;
                                irq_ctrl_next = data_reg;
                            end else if (cmd_sel_reg == cbm_pkg::CS_CNT_LO) begin
                                irq_cnt_next = {irq_cnt_reg[15:8], data_reg};
                            end else begin
                                irq_cnt_next = {data_reg, irq_cnt_reg[7:0]};
                            end
                        end
                    end
                    m_valid_next  = 1'b1;
                    m_kind_next   = res_kind;
                    m_off_next    = res_off & OFF_MASK;
                    m_slot_next   = res_slot;
                    m_mirror_next = mirror_next;
                    m_irq_next    = irq_pend_next;
                end
            end
            default: begin
                state_next = cbm_pkg::ST_IDLE;
            end
        endcase

        // The user must write configuration only while no item is in flight; not enforced here.
        if (cfg_we) begin
            if (cfg_index == cbm_pkg::CFG_PRG_COUNT) begin
                prg_count_next = cfg_wdata[cbm_pkg::PRG_COUNT_W-1:0];
                for (int i = 0; i < cbm_pkg::PRG_SLOTS; i++) begin
                    prg_bank_next[i] =
                        cbm_pkg::prg_preset(cfg_wdata[cbm_pkg::PRG_COUNT_W-1:0]);
                end
            end else if (cfg_index == cbm_pkg::CFG_CHR_COUNT) begin
                chr_count_next = cfg_wdata;
            end else if (cfg_index == cbm_pkg::CFG_RAM) begin
                ram_present_next = cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= cbm_pkg::ST_IDLE;
            m_valid_reg     <= 1'b0;
            m_mirror_reg    <= '0;
            m_irq_reg       <= 1'b0;
            prg_count_reg   <= cbm_pkg::PRG_COUNT_RESET;
            chr_count_reg   <= cbm_pkg::CHR_COUNT_RESET;
            ram_present_reg <= 1'b1;
            cmd_sel_reg     <= '0;
            for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++) begin
                chr_bank_reg[i] <= cbm_pkg::CHR_BANK_W'(i);
            end
            win_is_ram_reg  <= 1'b1;
            win_bank_reg    <= '0;
            for (int i = 0; i < cbm_pkg::PRG_SLOTS; i++) begin
                prg_bank_reg[i] <= cbm_pkg::prg_preset(cbm_pkg::PRG_COUNT_RESET);
            end
            irq_ctrl_reg    <= '0;
            irq_cnt_reg     <= '0;
            irq_pend_reg    <= 1'b0;
            mirror_reg      <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            m_mirror_reg    <= m_mirror_next;
            m_irq_reg       <= m_irq_next;
            prg_count_reg   <= prg_count_next;
            chr_count_reg   <= chr_count_next;
            ram_present_reg <= ram_present_next;
            cmd_sel_reg     <= cmd_sel_next;
            chr_bank_reg    <= chr_bank_next;
            win_is_ram_reg  <= win_is_ram_next;
            win_bank_reg    <= win_bank_next;
            prg_bank_reg    <= prg_bank_next;
            irq_ctrl_reg    <= irq_ctrl_next;
            irq_cnt_reg     <= irq_cnt_next;
            irq_pend_reg    <= irq_pend_next;
            mirror_reg      <= mirror_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        data_reg   <= data_next;
        den_reg    <= den_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        m_kind_reg <= m_kind_next;
        m_off_reg  <= m_off_next;
        m_slot_reg <= m_slot_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {6'd0, m_irq_reg, m_mirror_reg, m_slot_reg, m_off_reg};

endmodule
